@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/ssce_pkg.sv @@
// Package: types, command constants and segment tables of the command encoder.
`default_nettype none
package ssce_pkg;

  typedef enum logic [2:0] {
    MODE_DIGIT      = 3'd0,
    MODE_UNSIGNED   = 3'd1,
    MODE_SIGNED     = 3'd2,
    MODE_TEXT       = 3'd3,
    MODE_POWER_ON   = 3'd4,
    MODE_BRIGHTNESS = 3'd5,
    MODE_POWER_OFF  = 3'd6
  } mode_t;

  localparam int CNT_W = 4;  // byte count of one run, up to eight bytes

  localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
  localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
  localparam logic [7:0] CMD_ADDR       = 8'hC0;
  localparam logic [7:0] CMD_DISP_ON    = 8'd136;
  localparam logic [7:0] CMD_DISP_OFF   = 8'd128;
  localparam logic [7:0] SEG_MINUS      = 8'd64;
  localparam logic [7:0] SEG_BLANK      = 8'd0;

  // run description handed down the pipeline to the serializer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       hdr0;
    logic [7:0]       hdr1;
    logic [7:0]       single;
    logic             seg_run;
  } run_ctrl_t;

  // per-lane operands
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  ch;
    logic        ch_en;
    logic        text;
    logic        minus;
  } lane_in_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'd63;
      4'd1: s = 8'd6;
      4'd2: s = 8'd91;
      4'd3: s = 8'd79;
      4'd4: s = 8'd102;
      4'd5: s = 8'd109;
      4'd6: s = 8'd125;
      4'd7: s = 8'd7;
      4'd8: s = 8'd127;
      4'd9: s = 8'd111;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] letter_seg(input logic [4:0] i);
    logic [7:0] s;
    case (i)
      5'd0:  s = 8'd119;
      5'd1:  s = 8'd127;
      5'd2:  s = 8'd57;
      5'd3:  s = 8'd63;
      5'd4:  s = 8'd121;
      5'd5:  s = 8'd113;
      5'd6:  s = 8'd125;
      5'd7:  s = 8'd118;
      5'd8:  s = 8'd6;
      5'd9:  s = 8'd31;
      5'd10: s = 8'd121;
      5'd11: s = 8'd56;
      5'd12: s = 8'd55;
      5'd13: s = 8'd116;
      5'd14: s = 8'd63;
      5'd15: s = 8'd115;
      5'd16: s = 8'd103;
      5'd17: s = 8'd119;
      5'd18: s = 8'd109;
      5'd19: s = 8'd7;
      5'd20: s = 8'd62;
      5'd21: s = 8'd62;
      5'd22: s = 8'd1;
      5'd23: s = 8'd118;
      5'd24: s = 8'd102;
      5'd25: s = 8'd91;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // ASCII to segments, case-insensitive; anything else is blank
  function automatic logic [7:0] char_seg(input logic [7:0] c);
    logic [7:0] s;
    logic [7:0] off;
    s   = SEG_BLANK;
    off = 8'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      off = c - 8'd65;
      s   = letter_seg(off[4:0]);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      off = c - 8'd97;
      s   = letter_seg(off[4:0]);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      off = c - 8'd48;
      s   = digit_seg(off[3:0]);
    end
    return s;
  endfunction

  function automatic int unsigned pow10(input int k);
    int unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ssce_if.sv @@
// Channel interfaces: request channel and command byte channel.
`default_nettype none
interface ssce_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] number;
  logic [3:0]  digit_value;
  logic [2:0]  position;
  logic [7:0]  char_first;
  logic [7:0]  char_second;
  logic [7:0]  char_third;
  logic [7:0]  char_fourth;
  logic [2:0]  text_length;
  logic [3:0]  brightness;

  modport source (
    output valid, mode, number, digit_value, position, char_first, char_second,
           char_third, char_fourth, text_length, brightness,
    input  ready
  );
  modport sink (
    input  valid, mode, number, digit_value, position, char_first, char_second,
           char_third, char_fourth, text_length, brightness,
    output ready
  );
endinterface

interface ssce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       frame_start;
  logic       last;

  modport source (output valid, wire_byte, frame_start, last, input ready);
  modport sink (input valid, wire_byte, frame_start, last, output ready);
endinterface
`default_nettype wire

@@ hdl/ssce_lane.sv @@
// One display position: decimal digit extraction and text lookup, three stages.
`default_nettype none
module ssce_lane import ssce_pkg::*; #(
  parameter int unsigned POW = 1  // weight of this position, 10^k
) (
  input  logic       clk,
  input  logic       en,
  input  lane_in_t   din,
  output logic [7:0] seg
);

  // exact floor division for 16-bit dividends: ceil(2^33 / d), d < 2^17
  localparam logic [33:0] RECIP   = 34'(((64'd1 << 33) + 64'(POW) - 64'd1) / 64'(POW));
  localparam logic [33:0] RECIP10 = 34'(((64'd1 << 33) + 64'd9) / 64'd10);

  logic [49:0] prod1;
  logic [49:0] prod2;
  logic [15:0] q1_r, q2_r, t2_r;
  logic [7:0]  txt1_r, txt2_r;
  logic        text1_r, text2_r, minus1_r, minus2_r;
  logic [15:0] rem;
  logic [7:0]  seg_r;

  assign prod1 = 50'(din.value) * 50'(RECIP);
  assign prod2 = 50'(q1_r) * 50'(RECIP10);
  assign rem   = q2_r - 16'(t2_r * 16'd10);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: value / 10^k
      q1_r     <= prod1[48:33];
      txt1_r   <= din.ch_en ? char_seg(din.ch) : SEG_BLANK;
      text1_r  <= din.text;
      minus1_r <= din.minus;
      // stage 2: quotient / 10
      q2_r     <= q1_r;
      t2_r     <= prod2[48:33];
      txt2_r   <= txt1_r;
      text2_r  <= text1_r;
      minus2_r <= minus1_r;
      // stage 3: text, minus sign or remainder to segments
      if (text2_r) begin
        seg_r <= txt2_r;
      end else if (minus2_r) begin
        seg_r <= SEG_MINUS;
      end else begin
        seg_r <= digit_seg(rem[3:0]);
      end
    end
  end

  assign seg = seg_r;

endmodule
`default_nettype wire

@@ hdl/ssce_ser.sv @@
// Merge of lane results into a byte run and the byte serializer with output register.
`default_nettype none
module ssce_ser import ssce_pkg::*; #(
  parameter int DIGITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pend_valid,
  input  run_ctrl_t              pend_ctrl,
  input  logic [DIGITS-1:0][7:0] pend_seg,
  output logic                   load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_fs,
  output logic                   out_last
);

  localparam int NB = DIGITS + 2;

  logic [7:0]       fb [NB];
  logic             ff [NB];
  logic [7:0]       sb_r [NB-1];
  logic             sf_r [NB-1];
  logic [CNT_W-1:0] rem_r;
  logic             out_valid_r, fs_r, last_r;
  logic [7:0]       byte_r;
  logic             adv, have;

  assign adv  = !out_valid_r || out_ready;
  assign have = rem_r != '0;
  assign load = adv && !have && pend_valid;

  // merge: two header bytes, then one byte per lane or the single digit
  always_comb begin
    fb[0] = pend_ctrl.hdr0;
    ff[0] = 1'b1;
    fb[1] = pend_ctrl.hdr1;
    ff[1] = 1'b1;
    for (int p = 0; p < DIGITS; p++) begin
      if (pend_ctrl.seg_run) begin
        fb[p+2] = pend_seg[p];
      end else if (p == 0) begin
        fb[p+2] = pend_ctrl.single;
      end else begin
        fb[p+2] = SEG_BLANK;
      end
      ff[p+2] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else if (adv) begin
      if (have) begin
        out_valid_r <= 1'b1;
        rem_r       <= rem_r - CNT_W'(1);
      end else if (pend_valid && pend_ctrl.count != '0) begin
        out_valid_r <= 1'b1;
        rem_r       <= pend_ctrl.count - CNT_W'(1);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (have) begin
        byte_r <= sb_r[0];
        fs_r   <= sf_r[0];
        last_r <= rem_r == CNT_W'(1);
        for (int i = 0; i < NB - 2; i++) begin
          sb_r[i] <= sb_r[i+1];
          sf_r[i] <= sf_r[i+1];
        end
      end else begin
        byte_r <= fb[0];
        fs_r   <= ff[0];
        last_r <= pend_ctrl.count == CNT_W'(1);
        for (int i = 0; i < NB - 1; i++) begin
          sb_r[i] <= fb[i+1];
          sf_r[i] <= ff[i+1];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = byte_r;
  assign out_fs    = fs_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

@@ hdl/seven_segment_command_encoder_top.sv @@
// Top level of the seven-segment command encoder.
`default_nettype none
`include "assert_macros.svh"
// Turns display requests into the byte runs of a multi-digit seven-segment
// driver chip: one out_ch beat per byte, frame_start on the header bytes,
// last on the final byte of each run. A digit request gives 3 bytes, a number
// or text request DIGITS+2 bytes, power on / brightness / power off 1 byte;
// invalid requests, power on while on and power off while off give none.
// Bytes leave at one per cycle while out_ch.ready stays high, back to back
// across requests; the byte serializer sets this pace. A request with no
// bytes still takes a serializer load slot, which leaves out_ch.valid low
// for a single cycle when the serializer is busy.
// A request is taken every cycle as long as the serializer keeps pace. On its
// way to out_ch the first byte passes the decode register, three lane stages
// (divide by 10^k, divide by 10, remainder to segments) and the output
// register. One lane per display position runs in parallel.
// The display_on flag is updated in request order when the beat is taken.
module seven_segment_command_encoder_top import ssce_pkg::*; #(
  parameter int DIGITS = 4  // display positions, 1..6
) (
  input  logic       clk,
  input  logic       rst_n,
  ssce_in_if.sink    in_ch,
  ssce_out_if.source out_ch
);

  localparam logic [CNT_W-1:0] DIG_CNT = CNT_W'(DIGITS);
  localparam logic [CNT_W-1:0] RUN_CNT = CNT_W'(DIGITS + 2);

  logic                   acc, en, load;
  logic                   display_on_r, display_on_nxt;
  run_ctrl_t              dec_ctrl;
  lane_in_t               dec_lane [DIGITS];
  logic                   neg;
  logic [15:0]            val;
  run_ctrl_t              ctrl_r [4];
  lane_in_t               lane_r [DIGITS];
  logic [3:0]             vld_r;
  logic [DIGITS-1:0][7:0] seg;

  // pipeline moves as a whole whenever its last stage is empty or drains
  assign en          = !vld_r[3] || load;
  assign in_ch.ready = en;
  assign acc         = in_ch.valid && in_ch.ready;

  // request decode
  always_comb begin
    dec_ctrl       = '0;
    neg            = 1'b0;
    display_on_nxt = display_on_r;
    case (mode_t'(in_ch.mode))
      MODE_DIGIT: begin
        if (in_ch.digit_value <= 4'd9 && {1'b0, in_ch.position} < DIG_CNT) begin
          dec_ctrl.count  = CNT_W'(3);
          dec_ctrl.hdr0   = CMD_DATA_FIXED;
          dec_ctrl.hdr1   = CMD_ADDR | {5'd0, in_ch.position};
          dec_ctrl.single = digit_seg(in_ch.digit_value);
        end
      end
      MODE_UNSIGNED, MODE_SIGNED, MODE_TEXT: begin
        dec_ctrl.count   = RUN_CNT;
        dec_ctrl.hdr0    = CMD_DATA_AUTO;
        dec_ctrl.hdr1    = CMD_ADDR;
        dec_ctrl.seg_run = 1'b1;
        neg = (mode_t'(in_ch.mode) == MODE_SIGNED) && in_ch.number[15];
      end
      MODE_POWER_ON: begin
        if (!display_on_r) begin
          dec_ctrl.count = CNT_W'(1);
          dec_ctrl.hdr0  = CMD_DISP_ON | {4'd0, in_ch.brightness};
          if (acc) begin
            display_on_nxt = 1'b1;
          end
        end
      end
      MODE_BRIGHTNESS: begin
        if (in_ch.brightness <= 4'd7) begin
          dec_ctrl.count = CNT_W'(1);
          dec_ctrl.hdr0  = CMD_DISP_ON | {4'd0, in_ch.brightness};
        end
      end
      MODE_POWER_OFF: begin
        if (display_on_r) begin
          dec_ctrl.count = CNT_W'(1);
          dec_ctrl.hdr0  = CMD_DISP_OFF;
          if (acc) begin
            display_on_nxt = 1'b0;
          end
        end
      end
      default: begin
        dec_ctrl = '0;
      end
    endcase
  end

  // negative numbers show a minus sign, then the magnitude
  assign val = neg ? 16'(16'd0 - in_ch.number) : in_ch.number;

  // lane p is display position p, most significant first
  always_comb begin
    for (int p = 0; p < DIGITS; p++) begin
      dec_lane[p].value = val;
      dec_lane[p].text  = mode_t'(in_ch.mode) == MODE_TEXT;
      dec_lane[p].minus = neg && (p == 0);
      dec_lane[p].ch_en = (3'(p) < in_ch.text_length) && (p < 4);
      if (p == 0) begin
        dec_lane[p].ch = in_ch.char_first;
      end else if (p == 1) begin
        dec_lane[p].ch = in_ch.char_second;
      end else if (p == 2) begin
        dec_lane[p].ch = in_ch.char_third;
      end else if (p == 3) begin
        dec_lane[p].ch = in_ch.char_fourth;
      end else begin
        dec_lane[p].ch = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      display_on_r <= 1'b0;
    end else begin
      display_on_r <= display_on_nxt;
      if (en) begin
        vld_r <= {vld_r[2:0], acc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r[0] <= dec_ctrl;
      ctrl_r[1] <= ctrl_r[0];
      ctrl_r[2] <= ctrl_r[1];
      ctrl_r[3] <= ctrl_r[2];
      for (int p = 0; p < DIGITS; p++) begin
        lane_r[p] <= dec_lane[p];
      end
    end
  end

  for (genvar p = 0; p < DIGITS; p++) begin : g_lane
    ssce_lane #(
      .POW (pow10(DIGITS - 1 - p))
    ) u_lane (
      .clk (clk),
      .en  (en),
      .din (lane_r[p]),
      .seg (seg[p])
    );
  end

  ssce_ser #(
    .DIGITS (DIGITS)
  ) u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .pend_valid (vld_r[3]),
    .pend_ctrl  (ctrl_r[3]),
    .pend_seg   (seg),
    .load       (load),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.wire_byte),
    .out_fs     (out_ch.frame_start),
    .out_last   (out_ch.last)
  );

  // power requests leave the on flag in the requested state
  `ASSERT_NEXT(a_pwr_on, clk, rst_n, acc && in_ch.mode == MODE_POWER_ON, display_on_r)
  `ASSERT_NEXT(a_pwr_off, clk, rst_n, acc && in_ch.mode == MODE_POWER_OFF, !display_on_r)
  // the on flag only moves on a request beat
  `ASSERT_IMPL(a_flag_acc, clk, rst_n, $past(rst_n) && !$stable(display_on_r), $past(acc))
  // a finished run waiting on the serializer is never dropped
  `ASSERT_NEXT(a_pend_hold, clk, rst_n, vld_r[3] && !load, vld_r[3])

endmodule
`default_nettype wire
